>>> sv/epoch_seconds_to_calendar_macros.svh
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar assertion macros
// Concurrent check macros shared by the calendar converter; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ESC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ESC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> sv/esc_pkg.sv
// ---------------------------------------------------------------------------
// esc_pkg
// Types, stage numbering and reciprocal constants for the epoch converter.
// ---------------------------------------------------------------------------
package esc_pkg;

   // pipeline stage numbering
   localparam int unsigned StgDays   = 0;
   localparam int unsigned StgSod    = 1;
   localparam int unsigned StgEra    = 2;
   localparam int unsigned StgDivA   = 3;
   localparam int unsigned StgSum    = 4;
   localparam int unsigned StgYoe    = 5;
   localparam int unsigned StgDoy    = 6;
   localparam int unsigned StgMp     = 7;
   localparam int unsigned StgOut    = 8;
   localparam int unsigned NumStages = 9;

   typedef logic [NumStages-1:0] stage_vec_type;

   // stage enables and valid bits handed to the datapath modules
   typedef struct packed {
      stage_vec_type en;
      stage_vec_type valid;
   } pipe_ctl_type;

   // field widths
   localparam int unsigned SecsW   = 31;
   localparam int unsigned DaysW   = 15;
   localparam int unsigned SodW    = 17;
   localparam int unsigned DoeW    = 18;
   localparam int unsigned MinTotW = 11;
   localparam int unsigned YoeW    = 9;
   localparam int unsigned DoyW    = 9;
   localparam int unsigned MpW     = 4;
   localparam int unsigned YearW   = 11;
   localparam int unsigned MonthW  = 4;
   localparam int unsigned DayW    = 5;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinuteW = 6;
   localparam int unsigned SecondW = 6;

   typedef struct packed {
      logic [SecondW-1:0] second;
      logic [MinuteW-1:0] minute;
      logic [HourW-1:0]   hour;
   } clock_fields_type;

   typedef struct packed {
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
   } date_fields_type;

   // calendar constants
   localparam int unsigned SecsPerDay   = 86400;
   localparam int unsigned SecsPerMin   = 60;
   localparam int unsigned MinsPerHour  = 60;
   localparam int unsigned DaysShift    = 719468;
   localparam int unsigned DaysPerEra   = 146097;
   localparam int unsigned YearsPerEra  = 400;
   localparam int unsigned DaysPerYear  = 365;
   localparam int unsigned BaseEra      = DaysShift / DaysPerEra;
   localparam int unsigned EraOffset    = DaysShift - BaseEra * DaysPerEra;
   localparam int unsigned YearBase     = BaseEra * YearsPerEra;
   localparam int unsigned LastEraDay   = DaysPerEra - 1;
   localparam int unsigned JanIndex     = 10;
   localparam int unsigned MonthShiftUp = 3;
   localparam int unsigned MonthShiftDn = 9;

   // floor(x / d) = (x * ceil(2^k / d)) >> k, exact over each operand range
   // seconds to days: (secs >> 7) / 675
   localparam int unsigned DayPreShift = 7;
   localparam int unsigned DayDivD     = 675;
   localparam int unsigned DayDivK     = 34;
   localparam int unsigned DayRecipW   = 25;
   localparam logic [63:0] DayRecipFull =
      ((64'd1 << DayDivK) + 64'(DayDivD) - 64'd1) / 64'(DayDivD);
   localparam logic [DayRecipW-1:0] DayRecip = DayRecipFull[DayRecipW-1:0];

   // seconds of day to whole minutes: (sod >> 2) / 15
   localparam int unsigned MinDivD   = 15;
   localparam int unsigned MinDivK   = 20;
   localparam int unsigned MinRecipW = 17;
   localparam logic [63:0] MinRecipFull =
      ((64'd1 << MinDivK) + 64'(MinDivD) - 64'd1) / 64'(MinDivD);
   localparam logic [MinRecipW-1:0] MinRecip = MinRecipFull[MinRecipW-1:0];

   // minutes of day to hours: (mintot >> 2) / 15
   localparam int unsigned HourDivD   = 15;
   localparam int unsigned HourDivK   = 16;
   localparam int unsigned HourRecipW = 13;
   localparam logic [63:0] HourRecipFull =
      ((64'd1 << HourDivK) + 64'(HourDivD) - 64'd1) / 64'(HourDivD);
   localparam logic [HourRecipW-1:0] HourRecip = HourRecipFull[HourRecipW-1:0];

   // day of era / 1460
   localparam int unsigned QuadDivD   = 1460;
   localparam int unsigned QuadDivK   = 29;
   localparam int unsigned QuadRecipW = 19;
   localparam logic [63:0] QuadRecipFull =
      ((64'd1 << QuadDivK) + 64'(QuadDivD) - 64'd1) / 64'(QuadDivD);
   localparam logic [QuadRecipW-1:0] QuadRecip = QuadRecipFull[QuadRecipW-1:0];

   // day of era / 36524
   localparam int unsigned CentDivD   = 36524;
   localparam int unsigned CentDivK   = 34;
   localparam int unsigned CentRecipW = 19;
   localparam logic [63:0] CentRecipFull =
      ((64'd1 << CentDivK) + 64'(CentDivD) - 64'd1) / 64'(CentDivD);
   localparam logic [CentRecipW-1:0] CentRecip = CentRecipFull[CentRecipW-1:0];

   // adjusted day count / 365
   localparam int unsigned YearDivK   = 27;
   localparam int unsigned YearRecipW = 19;
   localparam logic [63:0] YearRecipFull =
      ((64'd1 << YearDivK) + 64'(DaysPerYear) - 64'd1) / 64'(DaysPerYear);
   localparam logic [YearRecipW-1:0] YearRecip = YearRecipFull[YearRecipW-1:0];

   // year of era / 100
   localparam int unsigned HundDivD   = 100;
   localparam int unsigned HundDivK   = 16;
   localparam int unsigned HundRecipW = 10;
   localparam logic [63:0] HundRecipFull =
      ((64'd1 << HundDivK) + 64'(HundDivD) - 64'd1) / 64'(HundDivD);
   localparam logic [HundRecipW-1:0] HundRecip = HundRecipFull[HundRecipW-1:0];

   // (5 * doy + 2) / 153
   localparam int unsigned MpDivD   = 153;
   localparam int unsigned MpDivK   = 19;
   localparam int unsigned MpRecipW = 12;
   localparam int unsigned MpMul    = 5;
   localparam int unsigned MpAdd    = 2;
   localparam int unsigned MpArgW   = 11;
   localparam logic [63:0] MpRecipFull =
      ((64'd1 << MpDivK) + 64'(MpDivD) - 64'd1) / 64'(MpDivD);
   localparam logic [MpRecipW-1:0] MpRecip = MpRecipFull[MpRecipW-1:0];

   // first day of each month in a march-based year, (153 * mp + 2) / 5
   function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
      logic [DoyW-1:0] ofs;
      case (mp)
         4'd0:    ofs = 9'd0;
         4'd1:    ofs = 9'd31;
         4'd2:    ofs = 9'd61;
         4'd3:    ofs = 9'd92;
         4'd4:    ofs = 9'd122;
         4'd5:    ofs = 9'd153;
         4'd6:    ofs = 9'd184;
         4'd7:    ofs = 9'd214;
         4'd8:    ofs = 9'd245;
         4'd9:    ofs = 9'd275;
         4'd10:   ofs = 9'd306;
         4'd11:   ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

>>> sv/esc_stage_ctrl.sv
// ---------------------------------------------------------------------------
// esc_stage_ctrl
// Valid bits and per-stage load enables; bubbles close up under a stall.
// ---------------------------------------------------------------------------
module esc_stage_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output esc_pkg::pipe_ctl_type pipe_ctl
);
   import esc_pkg::*;

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type stage_en;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      stage_en[NumStages-1] = !valid_ff[NumStages-1] || out_ready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NumStages; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready       = stage_en[0];
   assign out_valid      = valid_ff[NumStages-1];
   assign pipe_ctl.en    = stage_en;
   assign pipe_ctl.valid = valid_ff;

endmodule

>>> sv/esc_day_split.sv
// ---------------------------------------------------------------------------
// esc_day_split
// Splits the second count into whole days and seconds of the day.
// ---------------------------------------------------------------------------
module esc_day_split (
   input  logic                            clock,
   input  esc_pkg::pipe_ctl_type            pipe_ctl,
   input  logic [esc_pkg::SecsW-1:0]       secs,
   output logic [esc_pkg::SodW-1:0]        sod,
   output logic [esc_pkg::DoeW-1:0]        doe_pre
);
   import esc_pkg::*;

   localparam int unsigned HiW   = SecsW - DayPreShift;
   localparam int unsigned ProdW = HiW + DayRecipW;

   logic [ProdW-1:0] day_prod;
   logic [DaysW-1:0] days_in;
   logic [DaysW-1:0] days_ff;
   logic [SecsW-1:0] secs_ff;
   logic [SecsW-1:0] day_secs;
   logic [SodW-1:0]  sod_in;
   logic [SodW-1:0]  sod_ff;
   logic [DoeW-1:0]  doe_pre_in;
   logic [DoeW-1:0]  doe_pre_ff;

   // days = (secs >> 7) / 675 by reciprocal
   always_comb begin
      day_prod = ProdW'(secs[SecsW-1:DayPreShift]) * ProdW'(DayRecip);
      days_in  = day_prod[DayDivK +: DaysW];
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgDays]) begin
         days_ff <= days_in;
         secs_ff <= secs;
      end
   end

   // seconds left in the day, day count rebased to the era start
   always_comb begin
      day_secs   = SecsW'(days_ff) * SecsW'(SecsPerDay);
      sod_in     = SodW'(secs_ff - day_secs);
      doe_pre_in = DoeW'(days_ff) + DoeW'(EraOffset);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgSod]) begin
         sod_ff     <= sod_in;
         doe_pre_ff <= doe_pre_in;
      end
   end

   assign sod     = sod_ff;
   assign doe_pre = doe_pre_ff;

endmodule

>>> sv/esc_time_path.sv
// ---------------------------------------------------------------------------
// esc_time_path
// Hour, minute and second from the seconds of the day, delayed to the output.
// ---------------------------------------------------------------------------
module esc_time_path (
   input  logic                        clock,
   input  esc_pkg::pipe_ctl_type        pipe_ctl,
   input  logic [esc_pkg::SodW-1:0]    sod,
   output esc_pkg::clock_fields_type   fields
);
   import esc_pkg::*;

   localparam int unsigned MinArgW  = SodW - 2;
   localparam int unsigned MinProdW = MinArgW + MinRecipW;
   localparam int unsigned HrArgW   = MinTotW - 2;
   localparam int unsigned HrProdW  = HrArgW + HourRecipW;

   logic [MinProdW-1:0] min_prod;
   logic [MinTotW-1:0]  mintot_in;
   logic [MinTotW-1:0]  mintot_ff;
   logic [SodW-1:0]     sod_ff;
   logic [HrProdW-1:0]  hour_prod;
   logic [HourW-1:0]    hour_in;
   logic [SodW-1:0]     min_secs;
   logic [SecondW-1:0]  second_in;
   logic [MinTotW-1:0]  mintot3_ff;
   logic [HourW-1:0]    hour3_ff;
   logic [SecondW-1:0]  second3_ff;
   logic [MinTotW-1:0]  hour_mins;
   clock_fields_type    fields_in;
   clock_fields_type    dly_ff [StgSum:NumStages-1];

   // whole minutes of the day = (sod >> 2) / 15
   always_comb begin
      min_prod  = MinProdW'(sod[SodW-1:2]) * MinProdW'(MinRecip);
      mintot_in = min_prod[MinDivK +: MinTotW];
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgEra]) begin
         mintot_ff <= mintot_in;
         sod_ff    <= sod;
      end
   end

   // hour = (mintot >> 2) / 15, second from the leftover
   always_comb begin
      hour_prod = HrProdW'(mintot_ff[MinTotW-1:2]) * HrProdW'(HourRecip);
      hour_in   = hour_prod[HourDivK +: HourW];
      min_secs  = SodW'(mintot_ff) * SodW'(SecsPerMin);
      second_in = SecondW'(sod_ff - min_secs);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgDivA]) begin
         mintot3_ff <= mintot_ff;
         hour3_ff   <= hour_in;
         second3_ff <= second_in;
      end
   end

   // minute from the leftover of the hour
   always_comb begin
      hour_mins        = MinTotW'(hour3_ff) * MinTotW'(MinsPerHour);
      fields_in.hour   = hour3_ff;
      fields_in.minute = MinuteW'(mintot3_ff - hour_mins);
      fields_in.second = second3_ff;
   end

   // hold the time fields until the date is done
   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgSum]) begin
         dly_ff[StgSum] <= fields_in;
      end
      for (int s = StgSum + 1; s < NumStages; s++) begin
         if (pipe_ctl.en[s]) begin
            dly_ff[s] <= dly_ff[s-1];
         end
      end
   end

   assign fields = dly_ff[NumStages-1];

endmodule

>>> sv/esc_date_path.sv
// ---------------------------------------------------------------------------
// esc_date_path
// Civil date from the rebased day count: era, year of era, day of year, month.
// ---------------------------------------------------------------------------
module esc_date_path (
   input  logic                        clock,
   input  esc_pkg::pipe_ctl_type        pipe_ctl,
   input  logic [esc_pkg::DoeW-1:0]    doe_pre,
   output esc_pkg::date_fields_type    fields
);
   import esc_pkg::*;

   localparam int unsigned QuadProdW = DoeW + QuadRecipW;
   localparam int unsigned CentProdW = DoeW + CentRecipW;
   localparam int unsigned YearProdW = DoeW + YearRecipW;
   localparam int unsigned HundProdW = YoeW + HundRecipW;
   localparam int unsigned MpProdW   = MpArgW + MpRecipW;
   localparam int unsigned QuadW     = 7;
   localparam int unsigned CentW     = 3;
   localparam int unsigned HundW     = 3;

   // era fold
   logic              era_wrap;
   logic [DoeW-1:0]   doe_in;
   logic [DoeW-1:0]   doe2_ff;
   logic              era2_ff;
   // leap corrections
   logic [QuadProdW-1:0] quad_prod;
   logic [CentProdW-1:0] cent_prod;
   logic [QuadW-1:0]  quad_in;
   logic [CentW-1:0]  cent_in;
   logic [QuadW-1:0]  quad_ff;
   logic [CentW-1:0]  cent_ff;
   logic              last_ff;
   logic [DoeW-1:0]   doe3_ff;
   logic              era3_ff;
   // adjusted count
   logic [DoeW-1:0]   adj_in;
   logic [DoeW-1:0]   adj_ff;
   logic [DoeW-1:0]   doe4_ff;
   logic              era4_ff;
   // year of era
   logic [YearProdW-1:0] year_prod;
   logic [YoeW-1:0]   yoe_in;
   logic [YoeW-1:0]   yoe5_ff;
   logic [DoeW-1:0]   doe5_ff;
   logic              era5_ff;
   // day of year
   logic [HundProdW-1:0] hund_prod;
   logic [HundW-1:0]  hund;
   logic [DoeW-1:0]   days_before;
   logic [DoyW-1:0]   doy_in;
   logic [DoyW-1:0]   doy6_ff;
   logic [YoeW-1:0]   yoe6_ff;
   logic              era6_ff;
   // month index
   logic [MpArgW-1:0] mp_arg;
   logic [MpProdW-1:0] mp_prod;
   logic [MpW-1:0]    mp_in;
   logic [MpW-1:0]    mp7_ff;
   logic [DoyW-1:0]   doy7_ff;
   logic [YoeW-1:0]   yoe7_ff;
   logic              era7_ff;
   // output
   logic              jan_feb;
   date_fields_type   fields_in;
   date_fields_type   fields_ff;

   // fold the day count into the base era or the one after
   always_comb begin
      era_wrap = doe_pre >= DoeW'(DaysPerEra);
      doe_in   = era_wrap ? DoeW'(doe_pre - DoeW'(DaysPerEra)) : doe_pre;
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgEra]) begin
         doe2_ff <= doe_in;
         era2_ff <= era_wrap;
      end
   end

   // doe / 1460, doe / 36524 and the last day of the era
   always_comb begin
      quad_prod = QuadProdW'(doe2_ff) * QuadProdW'(QuadRecip);
      cent_prod = CentProdW'(doe2_ff) * CentProdW'(CentRecip);
      quad_in   = quad_prod[QuadDivK +: QuadW];
      cent_in   = cent_prod[CentDivK +: CentW];
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgDivA]) begin
         quad_ff <= quad_in;
         cent_ff <= cent_in;
         last_ff <= doe2_ff == DoeW'(LastEraDay);
         doe3_ff <= doe2_ff;
         era3_ff <= era2_ff;
      end
   end

   // day count with leap days taken out
   always_comb begin
      adj_in = doe3_ff - DoeW'(quad_ff) + DoeW'(cent_ff) - DoeW'(last_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgSum]) begin
         adj_ff  <= adj_in;
         doe4_ff <= doe3_ff;
         era4_ff <= era3_ff;
      end
   end

   // year of era = adjusted count / 365
   always_comb begin
      year_prod = YearProdW'(adj_ff) * YearProdW'(YearRecip);
      yoe_in    = year_prod[YearDivK +: YoeW];
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgYoe]) begin
         yoe5_ff <= yoe_in;
         doe5_ff <= doe4_ff;
         era5_ff <= era4_ff;
      end
   end

   // day of a march-based year
   always_comb begin
      hund_prod   = HundProdW'(yoe5_ff) * HundProdW'(HundRecip);
      hund        = hund_prod[HundDivK +: HundW];
      days_before = DoeW'(yoe5_ff) * DoeW'(DaysPerYear)
                    + DoeW'(yoe5_ff[YoeW-1:2]) - DoeW'(hund);
      doy_in      = DoyW'(doe5_ff - days_before);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgDoy]) begin
         doy6_ff <= doy_in;
         yoe6_ff <= yoe5_ff;
         era6_ff <= era5_ff;
      end
   end

   // month index = (5 * doy + 2) / 153
   always_comb begin
      mp_arg  = MpArgW'(doy6_ff) * MpArgW'(MpMul) + MpArgW'(MpAdd);
      mp_prod = MpProdW'(mp_arg) * MpProdW'(MpRecip);
      mp_in   = mp_prod[MpDivK +: MpW];
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgMp]) begin
         mp7_ff  <= mp_in;
         doy7_ff <= doy6_ff;
         yoe7_ff <= yoe6_ff;
         era7_ff <= era6_ff;
      end
   end

   // calendar month, day and year; january and february count to next year
   always_comb begin
      jan_feb         = mp7_ff >= MpW'(JanIndex);
      fields_in.month = jan_feb ? MonthW'(mp7_ff - MpW'(MonthShiftDn))
                                : MonthW'(mp7_ff + MpW'(MonthShiftUp));
      fields_in.day   = DayW'(doy7_ff - month_start(mp7_ff) + DoyW'(1));
      fields_in.year  = YearW'(YearBase) + (era7_ff ? YearW'(YearsPerEra) : YearW'(0))
                        + YearW'(yoe7_ff) + YearW'(jan_feb);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.en[StgOut]) begin
         fields_ff <= fields_in;
      end
   end

   assign fields = fields_ff;

endmodule

>>> sv/epoch_seconds_to_calendar.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Unix seconds to proleptic Gregorian date and time of day, fully pipelined.
// ---------------------------------------------------------------------------
//  channel | dir | handshake             | contents
//  --------+-----+-----------------------+-----------------------------------
//  req_    | in  | req_tvalid/req_tready | seconds since 1970-01-01 00:00:00
//  rsp_    | out | rsp_tvalid/rsp_tready | year, month, day, hour, min, sec
//
//  One transaction can enter every cycle while the pipeline is not full and
//  stalled. No stage chains more than one reciprocal multiply.
//  Reset clears only the valid bits of the 9 stages.
//  A stalled rsp holds its stage; earlier stages keep filling into bubbles,
//  so req_tready drops only when every stage holds a transaction.
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] seconds_since_epoch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [10:0] year, [14:11] month, [19:15] day,
                                    // [24:20] hour, [30:25] minute, [36:31] second
);
   import esc_pkg::*;

   localparam int unsigned RspFieldW = YearW + MonthW + DayW + HourW + MinuteW + SecondW;
   localparam int unsigned RspPadW   = 40 - RspFieldW;

   pipe_ctl_type     pipe_ctl;
   logic [SodW-1:0]  sod;
   logic [DoeW-1:0]  doe_pre;
   clock_fields_type clk_fields;
   date_fields_type  date_fields;

   // stage valid bits and load enables
   esc_stage_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .pipe_ctl  (pipe_ctl)
   );

   // days and seconds of the day
   esc_day_split u_split (
      .clock    (clock),
      .pipe_ctl (pipe_ctl),
      .secs     (req_tdata[SecsW-1:0]),
      .sod      (sod),
      .doe_pre  (doe_pre)
   );

   // time of day
   esc_time_path u_time (
      .clock    (clock),
      .pipe_ctl (pipe_ctl),
      .sod      (sod),
      .fields   (clk_fields)
   );

   // calendar date
   esc_date_path u_date (
      .clock    (clock),
      .pipe_ctl (pipe_ctl),
      .doe_pre  (doe_pre),
      .fields   (date_fields)
   );

   // result packing
   assign rsp_tdata = {RspPadW'(0), clk_fields.second, clk_fields.minute, clk_fields.hour,
                       date_fields.day, date_fields.month, date_fields.year};

   // checks
   `ESC_ASSERT_IMPLY(a_full_stall, clock, reset, (&pipe_ctl.valid) && !rsp_tready,
      !req_tready, "req_tready high with a full stalled pipeline")
   `ESC_ASSERT_NEXT(a_full_hold, clock, reset, (&pipe_ctl.valid) && !rsp_tready,
      &pipe_ctl.valid, "transaction dropped during a stall")
   `ESC_ASSERT_IMPLY(a_date_range, clock, reset, rsp_tvalid,
      date_fields.month >= 4'd1 && date_fields.month <= 4'd12 && date_fields.day >= 5'd1
      && date_fields.year >= 11'd1970 && date_fields.year <= 11'd2038,
      "date field out of range")
   `ESC_ASSERT_IMPLY(a_time_range, clock, reset, rsp_tvalid,
      clk_fields.hour <= 5'd23 && clk_fields.minute <= 6'd59 && clk_fields.second <= 6'd59,
      "time field out of range")

endmodule
